### rtl/adtp_pkg.sv
package adtp_pkg;

   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharN     = 8'h6E;

   localparam int MagWidth = 16;
   localparam int ProdWidth = 20;

   localparam logic [MagWidth-1:0] SatMag = 16'h8000;
   localparam logic [MagWidth-1:0] MaxPos = 16'h7FFF;

   typedef struct packed {
      logic                       value_valid;
      logic signed [MagWidth-1:0] value;
      logic [7:0]                 command_code;
   } result_type;

endpackage

### rtl/adtp_in_reg.sv
module adtp_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);
   import adtp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_in_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

### rtl/adtp_core.sv
module adtp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         in_byte,
   input  logic [7:0]         separator,
   output adtp_pkg::result_type result
);
   import adtp_pkg::*;

   logic [MagWidth-1:0]  mag_ff;
   logic [MagWidth-1:0]  mag_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic                 stopped_ff;
   logic                 stopped_in;
   logic                 nonempty_ff;
   logic                 nonempty_in;
   logic [7:0]           cmd_ff;
   logic [7:0]           cmd_in;
   logic [ProdWidth-1:0] prod;
   logic [3:0]           digit;
   logic                 emit;

   assign digit = 4'(in_byte - CharZero);
   assign prod  = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {16'b0, digit};

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      stopped_in   = stopped_ff;
      nonempty_in  = nonempty_ff;
      cmd_in       = cmd_ff;
      emit         = 1'b0;
      result.value = '0;
      if (in_byte == separator) begin
         if (nonempty_ff) begin
            emit = 1'b1;
            if (neg_ff) begin
               result.value = ~mag_ff + 16'd1;
            end else begin
               result.value = (mag_ff > MaxPos) ? MaxPos : mag_ff;
            end
            mag_in      = '0;
            neg_in      = 1'b0;
            stopped_in  = 1'b0;
            nonempty_in = 1'b0;
         end
      end else if (in_byte == CharMinus) begin
         if (!nonempty_ff) begin
            neg_in = 1'b1;
         end else begin
            stopped_in = 1'b1;
         end
         nonempty_in = 1'b1;
      end else if (in_byte == CharDot) begin
         stopped_in  = 1'b1;
         nonempty_in = 1'b1;
      end else if (in_byte >= CharZero && in_byte <= CharNine) begin
         if (!stopped_ff) begin
            mag_in = (prod > {4'b0, SatMag}) ? SatMag : prod[MagWidth-1:0];
         end
         nonempty_in = 1'b1;
      end else if (in_byte != CharN) begin
         cmd_in = in_byte;
      end
      result.value_valid  = emit;
      result.command_code = cmd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff      <= '0;
         neg_ff      <= 1'b0;
         stopped_ff  <= 1'b0;
         nonempty_ff <= 1'b0;
         cmd_ff      <= '0;
      end else if (step) begin
         mag_ff      <= mag_in;
         neg_ff      <= neg_in;
         stopped_ff  <= stopped_in;
         nonempty_ff <= nonempty_in;
         cmd_ff      <= cmd_in;
      end
   end

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      mag_ff <= SatMag)
      else $error("magnitude exceeds saturation limit");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      !result.value_valid |-> result.value == '0)
      else $error("value nonzero without completed token");

   a_token_cleared: assert property (@(posedge clock) disable iff (reset)
      step && result.value_valid |=> !nonempty_ff && mag_ff == '0 && !neg_ff)
      else $error("token not cleared after emission");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> mag_ff == '0 && !neg_ff && !stopped_ff)
      else $error("empty token carries state");

endmodule

### rtl/adtp_out_reg.sv
module adtp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  adtp_pkg::result_type result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 slot_free,
   output adtp_pkg::result_type rsp_result
);
   import adtp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

### rtl/ascii_decimal_token_parser.sv
// Parses a stream of ASCII bytes, one word per cycle when not stalled, into signed 16-bit
// integers. Digits, '-', '.' and the separator byte form a token; a leading '-' negates it,
// digits after the first '.' or a later '-' are ignored, and the value saturates to
// -32768..32767. Every accepted byte yields exactly one response word: value_valid is set
// when the byte is the separator ending a nonempty token, and command_code always shows the
// last byte that was none of a digit, '-', '.', the separator or 'n'. Throughput is one byte
// per cycle while responses are taken. A byte accepted into an input register passes
// through the token update logic and is captured in a response register once that register
// is free; a stalled response holds the input off. The separator register resets to zero
// and should be written only while no bytes are in flight.
module ascii_decimal_token_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_value_valid,
   output logic signed [15:0] rsp_value,
   output logic [7:0]        rsp_command_code,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_separator_byte
);
   import adtp_pkg::*;

   logic       item_valid;
   logic [7:0] item_byte;
   logic       slot_free;
   logic       advance;
   logic [7:0] separator_ff;
   result_type core_result;
   result_type out_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         separator_ff <= csr_separator_byte;
      end
   end

   assign advance = item_valid && slot_free;

   adtp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   adtp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (item_byte),
      .separator (separator_ff),
      .result    (core_result)
   );

   adtp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (core_result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .slot_free  (slot_free),
      .rsp_result (out_result)
   );

   assign rsp_value_valid  = out_result.value_valid;
   assign rsp_value        = out_result.value;
   assign rsp_command_code = out_result.command_code;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import adtp_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int PhaseCount = 9;
   localparam int TotalBytes = 1700;
   localparam int LongHold = 100;

   localparam logic [7:0] Comma     = 8'h2C;
   localparam logic [7:0] Space     = 8'h20;
   localparam logic [7:0] DigitFive = 8'h35;
   localparam logic [7:0] NulByte   = 8'h00;
   localparam logic [7:0] AllOnes   = 8'hFF;
   localparam logic [7:0] LetterA   = 8'h41;

   class token_scoreboard;
      logic [7:0]  separator;
      logic [15:0] magnitude;
      bit          negative;
      bit          stopped;
      bit          nonempty;
      logic [7:0]  held_cmd;
      result_type  expected_q[$];
      int          errors;
      int          words_checked;
      int          values_seen;

      function new();
         separator = NulByte;
         held_cmd = 8'h00;
         errors = 0;
         words_checked = 0;
         values_seen = 0;
         clear_token();
      endfunction

      function void clear_token();
         magnitude = 16'h0000;
         negative = 1'b0;
         stopped = 1'b0;
         nonempty = 1'b0;
      endfunction

      function void set_separator(logic [7:0] s);
         separator = s;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_byte(logic [7:0] b);
         result_type r;
         int         m;
         r = '0;
         if (b == separator) begin
            if (nonempty) begin
               r.value_valid = 1'b1;
               if (negative) begin
                  r.value = 16'h0000 - magnitude;
               end else begin
                  r.value = (magnitude > MaxPos) ? MaxPos : magnitude;
               end
               clear_token();
            end
         end else if (b == CharMinus) begin
            if (!nonempty) begin
               negative = 1'b1;
            end else begin
               stopped = 1'b1;
            end
            nonempty = 1'b1;
         end else if (b == CharDot) begin
            stopped = 1'b1;
            nonempty = 1'b1;
         end else if (b >= CharZero && b <= CharNine) begin
            if (!stopped) begin
               m = int'(magnitude) * 10 + (int'(b) - int'(CharZero));
               if (m > int'(SatMag)) begin
                  m = int'(SatMag);
               end
               magnitude = m[15:0];
            end
            nonempty = 1'b1;
         end else if (b != CharN) begin
            held_cmd = b;
         end
         r.command_code = held_cmd;
         expected_q.push_back(r);
      endfunction

      function void check_word(result_type got);
         result_type want;
         words_checked++;
         if (got.value_valid) begin
            values_seen++;
         end
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word: value_valid=%0b value=%0d command=%02h",
                     $time, got.value_valid, got.value, got.command_code);
            return;
         end
         want = expected_q.pop_front();
         if (got.value_valid !== want.value_valid) begin
            errors++;
            $display("%0t: value_valid expected %0b actual %0b",
                     $time, want.value_valid, got.value_valid);
         end
         if (got.value !== want.value) begin
            errors++;
            $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
         end
         if (got.command_code !== want.command_code) begin
            errors++;
            $display("%0t: command_code expected %02h actual %02h",
                     $time, want.command_code, got.command_code);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_in_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_value_valid;
   logic signed [15:0] rsp_value;
   logic [7:0]        rsp_command_code;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_separator_byte;

   token_scoreboard sb;
   int  bytes_sent;
   int  cycle_count;
   bit  sender_idles;
   bit  receiver_idles;
   bit  long_hold_request;
   logic [7:0] separator_list [0:PhaseCount-1];

   ascii_decimal_token_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_value_valid    (rsp_value_valid),
      .rsp_value          (rsp_value),
      .rsp_command_code   (rsp_command_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_separator_byte (csr_separator_byte)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles with %0d response words outstanding.",
                  cycle_count, sb.pending());
         $display("ascii_decimal_token_parser: mismatch");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task automatic end_token();
      send_byte(sb.separator);
   endtask

   task automatic send_digits(input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(CharZero + 8'($urandom_range(0, 9)));
      end
   endtask

   task automatic send_token();
      if ($urandom_range(0, 2) == 0) begin
         send_byte(CharMinus);
      end
      if ($urandom_range(0, 7) == 0) begin
         send_digits($urandom_range(5, 8));
      end else begin
         send_digits($urandom_range(0, 4));
      end
      if ($urandom_range(0, 3) == 0) begin
         send_byte($urandom_range(0, 1) ? CharDot : CharMinus);
         send_digits($urandom_range(0, 3));
      end
      if ($urandom_range(0, 9) != 0) begin
         end_token();
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_byte(CharN);
         1: send_byte(LetterA + 8'($urandom_range(0, 25)));
         default: send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic drain_responses();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_separator(input logic [7:0] s);
      csr_valid = 1'b1;
      csr_separator_byte = s;
      do @(posedge clock); while (!csr_ready);
      sb.set_separator(s);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      result_type got;
      int         gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = receiver_idles ? $urandom_range(0, 4) : 0;
         if (long_hold_request) begin
            gap = LongHold;
            long_hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.value_valid = rsp_value_valid;
         got.value = rsp_value;
         got.command_code = rsp_command_code;
         sb.check_word(got);
         @(negedge clock);
      end
   end

   initial begin
      int phase_end;
      sb = new();
      bytes_sent = 0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      long_hold_request = 1'b0;
      separator_list = '{Comma, AllOnes, CharDot, CharMinus, DigitFive, CharN, Space,
                         NulByte, NulByte};
      separator_list[PhaseCount-1] = 8'($urandom_range(0, 255));
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      csr_valid = 1'b0;
      csr_separator_byte = 8'h00;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      send_text("40000");
      end_token();
      send_text("-40000");
      end_token();
      send_text("4.2-3");
      end_token();
      send_text("-");
      end_token();
      send_text(".");
      end_token();
      end_token();
      send_byte(LetterA);
      send_byte(CharN);
      send_byte(AllOnes);
      drain_responses();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         write_separator(separator_list[phase]);
         sender_idles = (phase % 3) != 1;
         receiver_idles = (phase % 3) != 1;
         if (phase == 2) begin
            long_hold_request = 1'b1;
         end
         send_byte(NulByte);
         send_byte(CharN);
         send_token();
         end_token();
         phase_end = bytes_sent + TotalBytes / PhaseCount;
         while (bytes_sent < phase_end) begin
            if ($urandom_range(0, 4) == 0) begin
               send_noise();
            end else begin
               send_token();
            end
         end
         drain_responses();
      end

      repeat (8) @(negedge clock);
      $display("Covered %0d bytes under %0d separator settings, with one long response stall.",
               bytes_sent, PhaseCount + 1);
      $display("Checked %0d response words, %0d of them carrying a token value.",
               sb.words_checked, sb.values_seen);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ascii_decimal_token_parser: match");
      end else begin
         $display("ascii_decimal_token_parser: mismatch");
      end
      $finish;
   end

endmodule
